// File: hdl/kmdg_pkg.sv
// kmdg_pkg: shared types and constants for the key matrix debounce and ghost filter.
// No dependencies; imported by every module of the block.
package kmdg_pkg;

   localparam int KEY_LIMIT = 32;
   localparam int KEY_BITS  = $clog2(KEY_LIMIT);
   localparam int SCAN_W    = 32;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_ROW_COUNT      = 3'd0;
   localparam logic [2:0] CSR_COLUMN_COUNT   = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE_SCANS = 3'd2;
   localparam logic [2:0] CSR_HOLD_SCANS     = 3'd3;
   localparam logic [2:0] CSR_GHOST_SUPPRESS = 3'd4;
   localparam logic [2:0] CSR_HOLD_KEY_INDEX = 3'd5;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DOWN    = 3'd1,
      EV_UP      = 3'd2,
      EV_HOLD    = 3'd3,
      EV_INVALID = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GHOST,
      ST_WALK,
      ST_HOLD,
      ST_FLUSH,
      ST_INVALID
   } state_type;

   typedef struct packed {
      logic [5:0]  row_count;
      logic [5:0]  column_count;
      logic [15:0] settle_scans;
      logic [15:0] hold_scans;
      logic        ghost_suppress;
      logic [4:0]  hold_key_index;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic pair_step;
      logic key_step;
      logic hold_step;
      logic flush;
      logic invalid;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic size_bad;
      logic ghost_run;
      logic pair_last;
      logic key_last;
      logic key_event;
      logic hold_event;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

// File: hdl/kmdg_datapath.sv
// kmdg_datapath: scan register, ghost pair scanner, per-key debounce unit, hold tracker,
// pending-event slot and output register. Depends on kmdg_pkg; driven by kmdg_ctrl.
module kmdg_datapath #(
   parameter int AGE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kmdg_pkg::cfg_type        cfg,
   input  logic [31:0]              req_tdata,
   input  kmdg_pkg::cmd_type        cmd,
   output kmdg_pkg::status_type     st,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic [2:0]               rsp_tuser,
   output logic                     rsp_tlast
);
   import kmdg_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   function automatic logic [SCAN_W-1:0] low_mask(input logic [5:0] n);
      logic [SCAN_W-1:0] m;
      if (n >= 6'd32) m = '1;
      else            m = (SCAN_W'(1) << n[4:0]) - SCAN_W'(1);
      return m;
   endfunction

   logic [SCAN_W-1:0]   raw_ff, stable_ff, cand_ff, amb_ff;
   logic [AGE_BITS-1:0] age_ff [KEY_LIMIT];
   logic [AGE_BITS-1:0] hold_age_ff;
   logic                hold_fired_ff;
   logic                ghost_ff;
   logic [5:0]          pa_ff, pb_ff, offa_ff, offb_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                pend_valid_ff;
   kind_type            pend_kind_ff;
   logic [4:0]          pend_key_ff;
   logic                out_valid_ff;
   kind_type            out_kind_ff;
   logic [4:0]          out_key_ff;
   logic                out_ghost_ff, out_last_ff;

   logic [11:0]         keys;
   logic [SCAN_W-1:0]   scan_mask, col_mask;

   // ghost pair scan
   logic [SCAN_W-1:0]   row_a, row_b, common, amb_in;
   logic                multi, pair_wrap;

   // per-key debounce
   logic                req_b, stb_b, cand_b, same, fire;
   logic [AGE_BITS-1:0] age_cur, age_inc, age_new;

   // hold tracker
   logic                hold_b, hold_fire;
   logic [AGE_BITS-1:0] hold_inc;

   // event routing
   logic                ev_take, out_load, out_free;
   kind_type            ev_kind;
   logic [4:0]          ev_key;

   assign keys      = 12'(cfg.row_count) * 12'(cfg.column_count);
   assign scan_mask = low_mask(keys > 12'd32 ? 6'd32 : keys[5:0]);
   assign col_mask  = low_mask(cfg.column_count);

   assign row_a  = (raw_ff >> offa_ff[4:0]) & col_mask;
   assign row_b  = (raw_ff >> offb_ff[4:0]) & col_mask;
   assign common = row_a & row_b;
   assign multi  = (common & (common - SCAN_W'(1))) != '0;
   assign amb_in = multi ? (amb_ff | (common << offa_ff[4:0]) | (common << offb_ff[4:0]))
                         : amb_ff;
   assign pair_wrap = (pb_ff == cfg.row_count - 6'd1);

   assign req_b   = raw_ff[key_ff];
   assign stb_b   = stable_ff[key_ff];
   assign cand_b  = cand_ff[key_ff];
   assign age_cur = age_ff[key_ff];
   assign same    = (req_b == stb_b);
   assign age_inc = (age_cur == AGE_MAX) ? age_cur : age_cur + AGE_BITS'(1);
   assign age_new = (req_b != cand_b) ? AGE_BITS'(1) : age_inc;
   assign fire    = !same && (32'(age_new) >= 32'(cfg.settle_scans));

   assign hold_b    = stable_ff[cfg.hold_key_index];
   assign hold_inc  = (hold_age_ff == AGE_MAX) ? hold_age_ff : hold_age_ff + AGE_BITS'(1);
   assign hold_fire = hold_b && !hold_fired_ff && (32'(hold_inc) >= 32'(cfg.hold_scans));

   always_comb begin
      ev_take = 1'b0;
      ev_kind = EV_NONE;
      ev_key  = '0;
      if (cmd.key_step && fire) begin
         ev_take = 1'b1;
         ev_kind = req_b ? EV_DOWN : EV_UP;
         ev_key  = 5'(key_ff);
      end else if (cmd.hold_step && hold_fire) begin
         ev_take = 1'b1;
         ev_kind = EV_HOLD;
         ev_key  = cfg.hold_key_index;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = (ev_take && pend_valid_ff) || cmd.flush || cmd.invalid;

   always_comb begin
      st.size_bad   = (keys == 12'd0) || (keys > 12'(KEY_LIMIT));
      st.ghost_run  = cfg.ghost_suppress && (cfg.row_count >= 6'd2)
                      && (cfg.column_count >= 6'd2);
      st.pair_last  = pair_wrap && (pa_ff == cfg.row_count - 6'd2);
      st.key_last   = (12'(key_ff) == keys - 12'd1);
      st.key_event  = fire;
      st.hold_event = hold_fire;
      st.pend_valid = pend_valid_ff;
      st.out_free   = out_free;
   end

   // scan, ghost scan and counters
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff   <= req_tdata & scan_mask;
         amb_ff   <= '0;
         ghost_ff <= 1'b0;
         pa_ff    <= 6'd0;
         pb_ff    <= 6'd1;
         offa_ff  <= 6'd0;
         offb_ff  <= cfg.column_count;
         key_ff   <= '0;
      end else begin
         if (cmd.pair_step) begin
            amb_ff <= amb_in;
            if (pair_wrap) begin
               pa_ff   <= pa_ff + 6'd1;
               pb_ff   <= pa_ff + 6'd2;
               offa_ff <= offa_ff + cfg.column_count;
               offb_ff <= offa_ff + cfg.column_count + cfg.column_count;
            end else begin
               pb_ff   <= pb_ff + 6'd1;
               offb_ff <= offb_ff + cfg.column_count;
            end
            if (st.pair_last) begin
               // ambiguous keys fall back to their stable value
               raw_ff   <= (raw_ff & ~amb_in) | (stable_ff & amb_in);
               ghost_ff <= (amb_in != '0);
            end
         end
         if (cmd.key_step) key_ff <= key_ff + KEY_BITS'(1);
      end
   end

   // debounce and hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff     <= '0;
         cand_ff       <= '0;
         hold_age_ff   <= '0;
         hold_fired_ff <= 1'b0;
         for (int i = 0; i < KEY_LIMIT; i++) age_ff[i] <= '0;
      end else begin
         if (cmd.key_step) begin
            cand_ff[key_ff] <= req_b;
            if (same || fire) age_ff[key_ff] <= '0;
            else              age_ff[key_ff] <= age_new;
            if (fire) stable_ff[key_ff] <= req_b;
         end
         if (cmd.hold_step) begin
            if (hold_b) begin
               if (!hold_fired_ff) begin
                  hold_age_ff <= hold_inc;
                  if (hold_fire) hold_fired_ff <= 1'b1;
               end
            end else begin
               hold_age_ff   <= '0;
               hold_fired_ff <= 1'b0;
            end
         end
      end
   end

   // one-deep pending slot so the final event can carry tlast
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.load || cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end else if (ev_take) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_take) begin
         pend_kind_ff <= ev_kind;
         pend_key_ff  <= ev_key;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.invalid) begin
         out_kind_ff  <= EV_INVALID;
         out_key_ff   <= '0;
         out_ghost_ff <= 1'b0;
         out_last_ff  <= 1'b1;
      end else if (cmd.flush) begin
         out_kind_ff  <= pend_valid_ff ? pend_kind_ff : EV_NONE;
         out_key_ff   <= pend_valid_ff ? pend_key_ff : 5'd0;
         out_ghost_ff <= ghost_ff;
         out_last_ff  <= 1'b1;
      end else if (out_load) begin
         out_kind_ff  <= pend_kind_ff;
         out_key_ff   <= pend_key_ff;
         out_ghost_ff <= ghost_ff;
         out_last_ff  <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ghost_ff, out_key_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hdl/kmdg_ctrl.sv
// kmdg_ctrl: sequencer for one scan: ghost pair scan, key walk, hold check, final result.
// Depends on kmdg_pkg; commands kmdg_datapath.
module kmdg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  kmdg_pkg::status_type st,
   output kmdg_pkg::cmd_type    cmd
);
   import kmdg_pkg::*;

   state_type state_ff, state_in;
   logic      blocked;

   // an event that must push the pending one out waits for a free output register
   assign blocked = st.pend_valid && !st.out_free;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (st.size_bad) begin
                  state_in = ST_INVALID;
               end else begin
                  cmd.load = 1'b1;
                  state_in = st.ghost_run ? ST_GHOST : ST_WALK;
               end
            end
         end
         ST_GHOST: begin
            cmd.pair_step = 1'b1;
            if (st.pair_last) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!(st.key_event && blocked)) begin
               cmd.key_step = 1'b1;
               if (st.key_last) state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!(st.hold_event && blocked)) begin
               cmd.hold_step = 1'b1;
               state_in      = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_INVALID: begin
            if (st.out_free) begin
               cmd.invalid = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hdl/key_matrix_debounce_ghost_filter.sv
// key_matrix_debounce_ghost_filter: top level; configuration registers, sequencer and datapath.
// Depends on kmdg_pkg, kmdg_ctrl and kmdg_datapath.
//
// Takes one raw matrix scan per req transaction (bit row*columns+column) and streams the
// resulting events on rsp, one transaction per event, tlast on the last one of the scan.
// A scan with no events still gives one EV_NONE transaction. One scan is processed at a
// time: req_tready is high only between scans. Each scan is accepted, then its row pairs
// are compared when ghost suppression is on with at least two rows and two columns, then
// each key (rows*columns) goes through the single shared debounce unit, then come the
// hold check and the final result. An invalid key count (zero or above 32) leaves all
// state alone. The output register frees the walk from rsp_tready except when two
// events would be waiting at once.
module key_matrix_debounce_ghost_filter #(
   parameter int AGE_BITS = 16   // debounce and hold counter width, 4..16
) (
   input  logic        clock,
   input  logic        reset,
   // scan input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] scan_bits
   // event output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] key_index, [5] ghosting, [7:6] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   output logic        rsp_tlast,   // last_of_scan
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import kmdg_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type st;

   // register writes mask to the register width; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count      <= 6'd4;
         cfg_ff.column_count   <= 6'd8;
         cfg_ff.settle_scans   <= 16'd5;
         cfg_ff.hold_scans     <= 16'd500;
         cfg_ff.ghost_suppress <= 1'b0;
         cfg_ff.hold_key_index <= 5'd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROW_COUNT:      cfg_ff.row_count      <= csr_wdata[5:0];
            CSR_COLUMN_COUNT:   cfg_ff.column_count   <= csr_wdata[5:0];
            CSR_DEBOUNCE_SCANS: cfg_ff.settle_scans   <= csr_wdata;
            CSR_HOLD_SCANS:     cfg_ff.hold_scans     <= csr_wdata;
            CSR_GHOST_SUPPRESS: cfg_ff.ghost_suppress <= csr_wdata[0];
            CSR_HOLD_KEY_INDEX: cfg_ff.hold_key_index <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   kmdg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   kmdg_datapath #(
      .AGE_BITS (AGE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hdl/kmdg_checker.sv
// kmdg_checker: port-level assertions for key_matrix_debounce_ghost_filter, bound below.
// Depends on kmdg_pkg.
module kmdg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);
   import kmdg_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // one scan in flight: no second scan taken right after one
   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high in cycle after a scan was taken");

   // an invalid-size result is alone, keyless and without ghosting
   a_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_INVALID |-> rsp_tlast && rsp_tdata[5:0] == 6'd0)
      else $error("invalid-size result malformed");

   // a none result closes its scan and names no key
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_NONE |-> rsp_tlast && rsp_tdata[4:0] == 5'd0)
      else $error("none result malformed");

endmodule

bind key_matrix_debounce_ghost_filter kmdg_checker u_kmdg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: test/key_matrix_debounce_ghost_filter_tb.sv
`timescale 1ns / 100ps
// key_matrix_debounce_ghost_filter_tb: self-checking bench for the key matrix debounce and ghost
// filter. It predicts every event of every scan and compares the rsp stream against it.
// Depends on kmdg_pkg and key_matrix_debounce_ghost_filter.
module key_matrix_debounce_ghost_filter_tb;
   import kmdg_pkg::*;

   localparam logic [15:0] AGE_MAX       = 16'hFFFF;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 8;     // idle margin after the last event of a setup comes back
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_SCANS   = 58;
   // unused register slots: writes there must change nothing
   localparam logic [2:0]  CSR_SPARE_A   = 3'd6;
   localparam logic [2:0]  CSR_SPARE_B   = 3'd7;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] key;
      logic       ghost;
      logic       last;
   } event_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;       // [31:0] scan_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [4:0] key_index, [5] ghosting, [7:6] zero
   logic [2:0]  rsp_tuser;            // [2:0] event_kind
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   key_matrix_debounce_ghost_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor state: a shadow of the block's registers and key state, reset values included
   // ---------------------------------------------------------------------------------------
   logic [5:0]  cfg_rows       = 6'd4;
   logic [5:0]  cfg_cols       = 6'd8;
   logic [15:0] cfg_debounce   = 16'd5;
   logic [15:0] cfg_hold_scans = 16'd500;
   logic        cfg_ghost      = 1'b0;
   logic [4:0]  cfg_hold_key   = 5'd0;

   logic [31:0] stable_keys    = '0;
   logic [31:0] candidate_keys = '0;
   logic [15:0] cand_age [32]  = '{default: '0};
   logic [15:0] hold_age       = '0;
   logic        hold_fired     = 1'b0;

   logic [31:0]      pending_scans[$];    // scans waiting for the driver
   event_report_type expected_events[$];  // predicted rsp transactions, oldest first
   event_report_type head_ev;

   int  scans_sent, scans_taken, cycle_count, errors;
   int  n_none, n_down, n_up, n_hold, n_invalid, n_ghosted;
   int  req_gap, rsp_stall;
   bit  idle_enabled = 1'b1;

   // Keys in rows that share two or more pressed columns with another row.
   function automatic logic [31:0] find_ghost_keys(input logic [31:0] bits);
      logic [31:0] amb, col_mask, row_a, row_b, common;
      amb = '0;
      col_mask = (cfg_cols >= 6'd32) ? '1 : (32'd1 << cfg_cols) - 32'd1;
      for (int a = 0; a < int'(cfg_rows); a++) begin
         row_a = (bits >> (a * int'(cfg_cols))) & col_mask;
         for (int b = a + 1; b < int'(cfg_rows); b++) begin
            row_b = (bits >> (b * int'(cfg_cols))) & col_mask;
            common = row_a & row_b;
            if ((common & (common - 32'd1)) != '0)
               amb |= (common << (a * int'(cfg_cols))) | (common << (b * int'(cfg_cols)));
         end
      end
      return amb;
   endfunction

   // Runs one scan through the shadow state and queues the events it must produce.
   task automatic predict_scan(input logic [31:0] scan);
      int unsigned      n_keys;
      logic [31:0]      scan_mask, raw, amb;
      logic             want, ghost;
      kind_type         kinds[$];
      logic [4:0]       keys_hit[$];
      event_report_type item;
      n_keys = int'(cfg_rows) * int'(cfg_cols);
      if (n_keys == 0 || n_keys > KEY_LIMIT) begin
         // bad matrix size: one invalid transaction, state untouched
         item.kind  = EV_INVALID;
         item.key   = '0;
         item.ghost = 1'b0;
         item.last  = 1'b1;
         expected_events.push_back(item);
         return;
      end
      scan_mask = (n_keys == 32) ? '1 : (32'd1 << n_keys) - 32'd1;
      raw = scan & scan_mask;
      amb = '0;
      if (cfg_ghost) begin
         amb = find_ghost_keys(raw);
         raw = (raw & ~amb) | (stable_keys & amb);   // ambiguous keys keep their stable value
      end
      ghost = (amb != '0);

      for (int k = 0; k < int'(n_keys); k++) begin
         want = raw[k];
         if (want == stable_keys[k]) begin
            cand_age[k] = '0;
            candidate_keys[k] = want;
            continue;
         end
         if (want != candidate_keys[k]) begin
            candidate_keys[k] = want;
            cand_age[k] = 16'd1;
         end else if (cand_age[k] != AGE_MAX) begin
            cand_age[k]++;
         end
         if (cand_age[k] >= cfg_debounce) begin
            stable_keys[k] = want;
            cand_age[k] = '0;
            if (want) kinds.push_back(EV_DOWN);
            else kinds.push_back(EV_UP);
            keys_hit.push_back(5'(k));
         end
      end

      // long hold of the watched key: one event per hold, re-armed on release
      if (stable_keys[cfg_hold_key]) begin
         if (!hold_fired) begin
            if (hold_age != AGE_MAX) hold_age++;
            if (hold_age >= cfg_hold_scans) begin
               hold_fired = 1'b1;
               kinds.push_back(EV_HOLD);
               keys_hit.push_back(cfg_hold_key);
            end
         end
      end else begin
         hold_age = '0;
         hold_fired = 1'b0;
      end

      if (kinds.size() == 0) begin
         kinds.push_back(EV_NONE);
         keys_hit.push_back(5'd0);
      end
      foreach (kinds[i]) begin
         item.kind  = kinds[i];
         item.key   = keys_hit[i];
         item.ghost = ghost;
         item.last  = (i == kinds.size() - 1);
         expected_events.push_back(item);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Scan driver: one req transaction per queued scan, random gaps between transactions
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || scans_taken == scans_sent)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(1, 5) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_scans.size() > 0) begin
            req_tdata  <= pending_scans.pop_front();
            req_tvalid <= 1'b1;
            scans_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Event sink back-pressure: rsp_tready drops in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: checks rsp transactions, then predicts for each accepted req transaction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d events still expected", $time, expected_events.size());
         $display("key_matrix_debounce_ghost_filter_tb failed");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            case (rsp_tuser)
               EV_NONE:    n_none++;
               EV_DOWN:    n_down++;
               EV_UP:      n_up++;
               EV_HOLD:    n_hold++;
               EV_INVALID: n_invalid++;
               default:    ;
            endcase
            if (rsp_tdata[5]) n_ghosted++;
            if (expected_events.size() == 0) begin
               errors++;
               $display("%0t: unexpected event: kind %0d key %0d ghost %0b last %0b", $time,
                        rsp_tuser, rsp_tdata[4:0], rsp_tdata[5], rsp_tlast);
            end else begin
               head_ev = expected_events.pop_front();
               if (rsp_tuser !== head_ev.kind || rsp_tlast !== head_ev.last ||
                   rsp_tdata !== {2'b00, head_ev.ghost, head_ev.key}) begin
                  errors++;
                  $display("%0t: event mismatch: expected kind %0d key %0d ghost %0b last %0b",
                           $time, head_ev.kind, head_ev.key, head_ev.ghost, head_ev.last);
                  $display("%0t: actual kind %0d tdata %h last %0b",
                           $time, rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_scan(req_tdata);
            scans_taken++;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   task automatic push_scans(input logic [31:0] value, input int count);
      repeat (count) pending_scans.push_back(value);
   endtask

   // Wait until every scan went out and every event came back, then let the block go idle.
   task automatic settle();
      do @(negedge clock);
      while (pending_scans.size() != 0 || scans_taken != scans_sent ||
             expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; the shadow copy takes the value masked to the register width.
   task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_ROW_COUNT:      cfg_rows       = value[5:0];
         CSR_COLUMN_COUNT:   cfg_cols       = value[5:0];
         CSR_DEBOUNCE_SCANS: cfg_debounce   = value;
         CSR_HOLD_SCANS:     cfg_hold_scans = value;
         CSR_GHOST_SUPPRESS: cfg_ghost      = value[0];
         CSR_HOLD_KEY_INDEX: cfg_hold_key   = value[4:0];
         default:            ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random matrix shape and thresholds; junk in the unused upper bits of every narrow write.
   task automatic pick_random_config();
      int          r, c, keys;
      logic [15:0] junk, deb, hold;
      logic [4:0]  hkey;
      case ($urandom_range(0, 7))
         0:       begin r = 1;  c = $urandom_range(1, 32); end
         1:       begin r = 16; c = 2; end          // most row pairs to compare
         default: begin c = $urandom_range(1, 8); r = $urandom_range(1, 32 / c); end
      endcase
      keys = r * c;
      case ($urandom_range(0, 9))
         0:       deb = 16'd0;
         1:       deb = 16'($urandom_range(5, 12));
         default: deb = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
         0:       hold = 16'd0;
         1:       hold = 16'($urandom_range(20, 60));
         default: hold = 16'($urandom_range(1, 10));
      endcase
      if ($urandom_range(0, 4) == 0) hkey = 5'($urandom_range(0, 31));
      else hkey = 5'($urandom_range(0, keys - 1));
      junk = 16'($urandom);
      write_reg(CSR_ROW_COUNT, {junk[15:6], 6'(r)});
      junk = 16'($urandom);
      write_reg(CSR_COLUMN_COUNT, {junk[15:6], 6'(c)});
      write_reg(CSR_DEBOUNCE_SCANS, deb);
      write_reg(CSR_HOLD_SCANS, hold);
      junk = 16'($urandom);
      write_reg(CSR_GHOST_SUPPRESS, {junk[15:1], 1'($urandom_range(0, 1))});
      junk = 16'($urandom);
      write_reg(CSR_HOLD_KEY_INDEX, {junk[15:5], hkey});
   endtask

   // Mostly chords held for several scans (so debounce and hold can complete), with
   // contact bounce on single keys and the odd scan of pure noise.
   task automatic queue_random_scans(input int count);
      logic [31:0] held, scan;
      held = '0;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0:       held = $urandom & $urandom;
            1:       held = $urandom & $urandom & $urandom;
            2:       held = held ^ (32'd1 << $urandom_range(0, 31));
            3:       held = '0;
            4:       held = held | (32'd1 << cfg_hold_key);
            default: ;
         endcase
         case ($urandom_range(0, 11))
            0:       scan = $urandom;
            1:       scan = held ^ (32'd1 << $urandom_range(0, 31));
            default: scan = held;
         endcase
         pending_scans.push_back(scan);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values (4x8, debounce 5): all 32 keys go down together, then up together.
      push_scans(32'h0000_0000, 1);
      push_scans(32'hFFFF_FFFF, 6);
      push_scans(32'h0000_0000, 5);
      settle();

      // Thresholds of zero, ghost suppression on, upper write bits masked, spare slots ignored.
      write_reg(CSR_ROW_COUNT, 16'hFFC4);
      write_reg(CSR_COLUMN_COUNT, 16'h7F48);
      write_reg(CSR_DEBOUNCE_SCANS, 16'h0000);
      write_reg(CSR_HOLD_SCANS, 16'h0000);
      write_reg(CSR_GHOST_SUPPRESS, 16'hFFFF);
      write_reg(CSR_HOLD_KEY_INDEX, 16'hFFE3);
      write_reg(CSR_SPARE_A, 16'h0001);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      push_scans(32'hFFFF_FFFF, 1);   // every key ambiguous: frozen, ghosting only
      push_scans(32'h0000_000F, 1);   // four downs plus the hold on key 3
      push_scans(32'h0000_0303, 1);   // rectangle in rows 0 and 1: keys 0,1 frozen
      push_scans(32'h0000_0000, 1);
      settle();

      // One row of 32 columns: 32 downs and a hold in a single scan, then 32 ups.
      write_reg(CSR_ROW_COUNT, 16'd1);
      write_reg(CSR_COLUMN_COUNT, 16'd32);
      write_reg(CSR_GHOST_SUPPRESS, 16'd0);
      write_reg(CSR_HOLD_KEY_INDEX, 16'd31);
      push_scans(32'hFFFF_FFFF, 1);
      push_scans(32'h0000_0000, 1);
      settle();

      // Invalid key counts: zero rows, 33 keys, largest register values.
      write_reg(CSR_ROW_COUNT, 16'd0);
      push_scans(32'hFFFF_FFFF, 1);
      settle();
      write_reg(CSR_ROW_COUNT, 16'd33);
      write_reg(CSR_COLUMN_COUNT, 16'd1);
      push_scans(32'hFFFF_FFFF, 1);
      settle();
      write_reg(CSR_ROW_COUNT, 16'd63);
      write_reg(CSR_COLUMN_COUNT, 16'd63);
      push_scans(32'hA5A5_5A5A, 1);
      settle();

      // 2x2 matrix, watched key out of range, largest thresholds: nothing completes.
      write_reg(CSR_ROW_COUNT, 16'd2);
      write_reg(CSR_COLUMN_COUNT, 16'd2);
      write_reg(CSR_HOLD_KEY_INDEX, 16'd20);
      write_reg(CSR_DEBOUNCE_SCANS, 16'hFFFF);
      write_reg(CSR_HOLD_SCANS, 16'hFFFF);
      push_scans(32'hFFFF_FFFF, 2);
      settle();
      write_reg(CSR_DEBOUNCE_SCANS, 16'd1);
      push_scans(32'hFFFF_FFFF, 1);   // four downs, masked to the 2x2 keys, no hold
      settle();

      // Random phases; the last one runs with no gaps and no back-pressure.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1) idle_enabled = 1'b0;
         pick_random_config();
         queue_random_scans(PHASE_SCANS);
         settle();
      end

      repeat (4 * SETTLE_CYCLES) @(negedge clock);
      $display("Covered %0d scans over %0d random setups; events: %0d none, %0d down, %0d up,",
               scans_taken, RANDOM_PHASES, n_none, n_down, n_up);
      $display("%0d hold, %0d invalid size, %0d flagged with ghosting.",
               n_hold, n_invalid, n_ghosted);
      if (errors == 0 && expected_events.size() == 0) begin
         $display("key_matrix_debounce_ghost_filter_tb passed");
      end else begin
         $display("key_matrix_debounce_ghost_filter_tb failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/kmdg_pkg.sv
hdl/kmdg_datapath.sv
hdl/kmdg_ctrl.sv
hdl/key_matrix_debounce_ghost_filter.sv
hdl/kmdg_checker.sv
test/key_matrix_debounce_ghost_filter_tb.sv
